FILE: rtl/core/y2rgb_pkg.sv
// ----------------------------------------------------------------------------
// y2rgb_pkg
// Shared constants and types for the YUYV 4:2:2 to RGB converter.
// ----------------------------------------------------------------------------
package y2rgb_pkg;

  localparam int COEF_FRAC_BITS = 16;
  // Largest coefficient is below 4.0, so two integer bits suffice.
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  // Sums stay below 1024 in magnitude before the fraction bits.
  localparam int SUM_W  = COEF_FRAC_BITS + 12;

  typedef logic signed [COEF_W:0]  coef_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [8:0]       diff_t;

  localparam longint unsigned DEC_SCALE = 64'd100000;
  localparam longint unsigned DEC_HALF  = 64'd50000;

  // Coefficients rounded half up to COEF_FRAC_BITS fraction bits.
  localparam coef_t COEF_RV =
    coef_t'(((64'd113983 << COEF_FRAC_BITS) + DEC_HALF) / DEC_SCALE);
  localparam coef_t COEF_GU =
    coef_t'(((64'd39465 << COEF_FRAC_BITS) + DEC_HALF) / DEC_SCALE);
  localparam coef_t COEF_GV =
    coef_t'(((64'd58060 << COEF_FRAC_BITS) + DEC_HALF) / DEC_SCALE);
  localparam coef_t COEF_BU =
    coef_t'(((64'd203211 << COEF_FRAC_BITS) + DEC_HALF) / DEC_SCALE);

  localparam diff_t CHROMA_MID = 9'sd128;

  localparam logic ORDER_RGB = 1'b0;
  localparam logic ORDER_BGR = 1'b1;

  typedef struct packed {
    sum_t rv;
    sum_t gu;
    sum_t gv;
    sum_t bu;
  } chroma_prod_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

endpackage

FILE: rtl/core/y2rgb_chroma.sv
// ----------------------------------------------------------------------------
// y2rgb_chroma
// Shared chroma stage: four coefficient products of the centered U/V pair.
// ----------------------------------------------------------------------------
module y2rgb_chroma (
  input  logic                     clk,
  input  logic                     load,
  input  logic [7:0]               chroma_blue,
  input  logic [7:0]               chroma_red,
  output y2rgb_pkg::chroma_prod_t  prod
);

  y2rgb_pkg::diff_t du;
  y2rgb_pkg::diff_t dv;

  assign du = y2rgb_pkg::diff_t'({1'b0, chroma_blue}) - y2rgb_pkg::CHROMA_MID;
  assign dv = y2rgb_pkg::diff_t'({1'b0, chroma_red}) - y2rgb_pkg::CHROMA_MID;

  always_ff @(posedge clk) begin
    if (load) begin
      prod.rv <= y2rgb_pkg::sum_t'(y2rgb_pkg::COEF_RV) * y2rgb_pkg::sum_t'(dv);
      prod.gu <= y2rgb_pkg::sum_t'(y2rgb_pkg::COEF_GU) * y2rgb_pkg::sum_t'(du);
      prod.gv <= y2rgb_pkg::sum_t'(y2rgb_pkg::COEF_GV) * y2rgb_pkg::sum_t'(dv);
      prod.bu <= y2rgb_pkg::sum_t'(y2rgb_pkg::COEF_BU) * y2rgb_pkg::sum_t'(du);
    end
  end

endmodule

FILE: rtl/core/y2rgb_lane.sv
// ----------------------------------------------------------------------------
// y2rgb_lane
// One pixel lane: adds/subtracts chroma products to scaled luma, truncates, clamps.
// ----------------------------------------------------------------------------
module y2rgb_lane (
  input  logic                     clk,
  input  logic                     load,
  input  logic [7:0]               luma,
  input  y2rgb_pkg::chroma_prod_t  prod,
  output y2rgb_pkg::pixel_t        pixel
);

  y2rgb_pkg::sum_t ys;
  y2rgb_pkg::sum_t sum_r;
  y2rgb_pkg::sum_t sum_g;
  y2rgb_pkg::sum_t sum_b;

  // Negative -> 0, else drop fraction bits and saturate at 255.
  function automatic logic [7:0] clamp_q(input y2rgb_pkg::sum_t s);
    logic [7:0] res;
    if (s[y2rgb_pkg::SUM_W-1]) begin
      res = 8'd0;
    end else if (|s[y2rgb_pkg::SUM_W-2:y2rgb_pkg::COEF_FRAC_BITS+8]) begin
      res = 8'd255;
    end else begin
      res = s[y2rgb_pkg::COEF_FRAC_BITS+7:y2rgb_pkg::COEF_FRAC_BITS];
    end
    return res;
  endfunction

  assign ys    = y2rgb_pkg::sum_t'({luma, {y2rgb_pkg::COEF_FRAC_BITS{1'b0}}});
  assign sum_r = ys + prod.rv;
  assign sum_g = ys - prod.gu - prod.gv;
  assign sum_b = ys + prod.bu;

  always_ff @(posedge clk) begin
    if (load) begin
      pixel.r <= clamp_q(sum_r);
      pixel.g <= clamp_q(sum_g);
      pixel.b <= clamp_q(sum_b);
    end
  end

endmodule

FILE: rtl/core/yuyv422_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// yuyv422_to_rgb_converter
// YUYV 4:2:2 macropixel to two RGB/BGR pixels, BT.601-style coefficients.
// ----------------------------------------------------------------------------
// Throughput: one macropixel per cycle while the output is not stalled; a
// shared chroma product stage feeds two pixel lanes, then an output
// register that does the channel ordering. Each stage holds while its
// successor is full and stalled, so bubbles are absorbed.
// Reset: synchronous, clears the stage valids; channel_order resets to BGR.
module yuyv422_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // channel_order
  input  logic        s_tvalid,
  output logic        s_tready,
  // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,       // frame_end_in
  output logic        m_tvalid,
  input  logic        m_tready,
  // first_c0[7:0], first_c1[15:8], first_c2[23:16],
  // second_c0[31:24], second_c1[39:32], second_c2[47:40]
  output logic [47:0] m_tdata,
  output logic        m_tlast        // frame_end_out
);

  logic channel_order;
  logic v1;
  logic v2;
  logic en1;
  logic en2;
  logic en3;

  logic [7:0] y0_s1;
  logic [7:0] y1_s1;
  logic       last_s1;
  logic       last_s2;

  y2rgb_pkg::chroma_prod_t prod;
  y2rgb_pkg::pixel_t       px_first;
  y2rgb_pkg::pixel_t       px_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_order <= y2rgb_pkg::ORDER_BGR;
    end else if (cfg_wr_en) begin
      channel_order <= cfg_wr_data;
    end
  end

  // A stage loads when it is empty or its successor is taking its item.
  assign en3      = !m_tvalid || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_tvalid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        m_tvalid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      y0_s1   <= s_tdata[7:0];
      y1_s1   <= s_tdata[23:16];
      last_s1 <= s_tlast;
    end
    if (en2) begin
      last_s2 <= last_s1;
    end
  end

  y2rgb_chroma u_chroma (
    .clk         (clk),
    .load        (en1),
    .chroma_blue (s_tdata[15:8]),
    .chroma_red  (s_tdata[31:24]),
    .prod        (prod)
  );

  y2rgb_lane u_lane_first (
    .clk   (clk),
    .load  (en2),
    .luma  (y0_s1),
    .prod  (prod),
    .pixel (px_first)
  );

  y2rgb_lane u_lane_second (
    .clk   (clk),
    .load  (en2),
    .luma  (y1_s1),
    .prod  (prod),
    .pixel (px_second)
  );

  // Merge: pack both pixels in the selected channel order.
  always_ff @(posedge clk) begin
    if (en3) begin
      m_tlast        <= last_s2;
      m_tdata[15:8]  <= px_first.g;
      m_tdata[39:32] <= px_second.g;
      if (channel_order == y2rgb_pkg::ORDER_BGR) begin
        m_tdata[7:0]   <= px_first.b;
        m_tdata[23:16] <= px_first.r;
        m_tdata[31:24] <= px_second.b;
        m_tdata[47:40] <= px_second.r;
      end else begin
        m_tdata[7:0]   <= px_first.r;
        m_tdata[23:16] <= px_first.b;
        m_tdata[31:24] <= px_second.r;
        m_tdata[47:40] <= px_second.b;
      end
    end
  end

  // Input may only stall when every stage is full and the output is held.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && m_tvalid && !m_tready))
    else $error("input stalled with room in the pipeline");

  // An accepted item occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted item lost at first stage");

  // A held result must stay valid until taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("pending result dropped or changed");

endmodule

FILE: tb/tb_yuyv422_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuyv422_to_rgb_converter
// Self-checking bench for the YUYV 4:2:2 to RGB/BGR converter. Macropixels go
// in on the slave stream with random gaps, results are taken on the master
// stream with random stalls, and every result is compared channel by channel
// against a fixed-point color model kept in the bench. Both channel orders,
// rail clamping at 0 and 255, and frame-end pass-through are covered.
// ----------------------------------------------------------------------------
module tb_yuyv422_to_rgb_converter;

  localparam int FRAC       = y2rgb_pkg::COEF_FRAC_BITS;
  localparam int IDLE_PCT   = 17;
  localparam int STALL_MAX  = 5000;
  localparam int PRINT_MAX  = 20;
  localparam int DRAIN_WAIT = 8;

  // Coefficients rounded half up to FRAC fraction bits
  localparam longint K_RV = ((64'sd113983 <<< FRAC) + 64'sd50000) / 64'sd100000;
  localparam longint K_GU = ((64'sd39465  <<< FRAC) + 64'sd50000) / 64'sd100000;
  localparam longint K_GV = ((64'sd58060  <<< FRAC) + 64'sd50000) / 64'sd100000;
  localparam longint K_BU = ((64'sd203211 <<< FRAC) + 64'sd50000) / 64'sd100000;

  typedef struct {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end;
  } macropixel_t;

  typedef struct {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } px_out_t;

  typedef struct {
    px_out_t first;
    px_out_t second;
    logic    frame_end;
  } pixel_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  logic        pixel_order = y2rgb_pkg::ORDER_BGR;  // bench copy of channel_order
  bit          steady_run = 1'b0;                   // no gaps and no stalls while set
  pixel_pair_t pending_pairs[$];
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_rail = 0;
  int          n_frame_end = 0;
  int          n_order_writes = 0;

  always #2 clk = ~clk;

  yuyv422_to_rgb_converter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  function automatic logic [7:0] clamp_channel(longint acc);
    longint whole;
    if (acc < 0) return 8'd0;
    whole = acc >>> FRAC;
    return (whole > 255) ? 8'd255 : whole[7:0];
  endfunction

  function automatic px_out_t shade_pixel(logic [7:0] y, longint du, longint dv,
                                          logic order);
    longint     ys;
    logic [7:0] r, g, b;
    px_out_t    px;
    ys = y;
    ys = ys <<< FRAC;
    r = clamp_channel(ys + K_RV * dv);
    g = clamp_channel(ys - K_GU * du - K_GV * dv);
    b = clamp_channel(ys + K_BU * du);
    px.c1 = g;
    if (order == y2rgb_pkg::ORDER_BGR) begin
      px.c0 = b;
      px.c2 = r;
    end else begin
      px.c0 = r;
      px.c2 = b;
    end
    return px;
  endfunction

  function automatic pixel_pair_t convert_macropixel(macropixel_t mp, logic order);
    longint      du, dv;
    pixel_pair_t pair;
    du = mp.chroma_blue;
    du = du - 128;
    dv = mp.chroma_red;
    dv = dv - 128;
    pair.first     = shade_pixel(mp.luma_first, du, dv, order);
    pair.second    = shade_pixel(mp.luma_second, du, dv, order);
    pair.frame_end = mp.frame_end;
    return pair;
  endfunction

  function automatic int rail_hits(px_out_t px);
    return int'(px.c0 == 8'd0 || px.c0 == 8'd255) + int'(px.c1 == 8'd0 || px.c1 == 8'd255)
         + int'(px.c2 == 8'd0 || px.c2 == 8'd255);
  endfunction

  // Biased byte: rails, near the chroma midpoint, near the ends, or anything
  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(120, 136));
      3:       return 8'($urandom_range(0, 15));
      4:       return 8'($urandom_range(240, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic macropixel_t random_macropixel(bit biased);
    macropixel_t mp;
    if (biased) begin
      mp.luma_first  = edgy_byte();
      mp.chroma_blue = edgy_byte();
      mp.luma_second = edgy_byte();
      mp.chroma_red  = edgy_byte();
    end else begin
      mp.luma_first  = 8'($urandom);
      mp.chroma_blue = 8'($urandom);
      mp.luma_second = 8'($urandom);
      mp.chroma_red  = 8'($urandom);
    end
    mp.frame_end = ($urandom_range(0, 7) == 0);
    return mp;
  endfunction

  function automatic macropixel_t mk_mp(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                        logic [7:0] v, logic last);
    macropixel_t mp;
    mp.luma_first  = y0;
    mp.chroma_blue = u;
    mp.luma_second = y1;
    mp.chroma_red  = v;
    mp.frame_end   = last;
    return mp;
  endfunction

  task automatic report_mismatch(string what, int expv, int gotv);
    if (n_errors < PRINT_MAX)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expv, gotv);
    n_errors++;
  endtask

  task automatic send_macropixel(macropixel_t mp);
    pixel_pair_t pair;
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {mp.chroma_red, mp.luma_second, mp.chroma_blue, mp.luma_first};
    s_tlast  <= mp.frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pair = convert_macropixel(mp, pixel_order);
    pending_pairs.push_back(pair);
    n_sent++;
    n_rail += rail_hits(pair.first) + rail_hits(pair.second);
    n_frame_end += mp.frame_end;
  endtask

  // Stop input, let every outstanding result arrive, then let the bench idle quietly
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_order(logic order);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pixel_order = order;
    n_order_writes++;
  endtask

  // Result checker
  always @(posedge clk) begin
    pixel_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = pending_pairs.pop_front();
        if (m_tdata[7:0] !== want.first.c0)
          report_mismatch("first_c0", want.first.c0, m_tdata[7:0]);
        if (m_tdata[15:8] !== want.first.c1)
          report_mismatch("first_c1", want.first.c1, m_tdata[15:8]);
        if (m_tdata[23:16] !== want.first.c2)
          report_mismatch("first_c2", want.first.c2, m_tdata[23:16]);
        if (m_tdata[31:24] !== want.second.c0)
          report_mismatch("second_c0", want.second.c0, m_tdata[31:24]);
        if (m_tdata[39:32] !== want.second.c1)
          report_mismatch("second_c1", want.second.c1, m_tdata[39:32]);
        if (m_tdata[47:40] !== want.second.c2)
          report_mismatch("second_c2", want.second.c2, m_tdata[47:40]);
        if (m_tlast !== want.frame_end)
          report_mismatch("frame_end", want.frame_end, m_tlast);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: ends the run after too many cycles without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_MAX);
    $display("*** FAILED ***");
    $finish;
  end

  // Reset value of the order register is BGR; no write before these items
  task automatic test_reset_order();
    send_macropixel(mk_mp(8'd128, 8'd128, 8'd128, 8'd128, 1'b0));
    send_macropixel(mk_mp(8'd80,  8'd90,  8'd80,  8'd240, 1'b0));
    send_macropixel(mk_mp(8'd40,  8'd240, 8'd200, 8'd110, 1'b1));
    send_macropixel(mk_mp(8'd0,   8'd0,   8'd255, 8'd255, 1'b0));
    send_macropixel(mk_mp(8'd255, 8'd255, 8'd0,   8'd0,   1'b1));
  endtask

  task automatic test_directed_extremes();
    write_order(y2rgb_pkg::ORDER_RGB);
    send_macropixel(mk_mp(8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
    send_macropixel(mk_mp(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_macropixel(mk_mp(8'd0,   8'd128, 8'd255, 8'd128, 1'b0));
    send_macropixel(mk_mp(8'd128, 8'd255, 8'd128, 8'd0,   1'b0));  // blue up, red down
    send_macropixel(mk_mp(8'd128, 8'd0,   8'd128, 8'd255, 1'b1));  // red up, blue down
    send_macropixel(mk_mp(8'd128, 8'd0,   8'd128, 8'd0,   1'b0));  // green up to 252, short of the top rail
    send_macropixel(mk_mp(8'd16,  8'd128, 8'd235, 8'd128, 1'b0));
    send_macropixel(mk_mp(8'd1,   8'd127, 8'd254, 8'd129, 1'b0));
    send_macropixel(mk_mp(8'd10,  8'd129, 8'd245, 8'd127, 1'b1));
    send_macropixel(mk_mp(8'd170, 8'd85,  8'd85,  8'd170, 1'b0));
    send_macropixel(mk_mp(8'd85,  8'd170, 8'd170, 8'd85,  1'b0));
    send_macropixel(mk_mp(8'd200, 8'd200, 8'd50,  8'd50,  1'b0));
    send_macropixel(mk_mp(8'd255, 8'd0,   8'd0,   8'd255, 1'b1));
    send_macropixel(mk_mp(8'd0,   8'd255, 8'd255, 8'd0,   1'b0));
    send_macropixel(mk_mp(8'd235, 8'd16,  8'd16,  8'd240, 1'b0));
    send_macropixel(mk_mp(8'd128, 8'd128, 8'd128, 8'd128, 1'b1));
  endtask

  task automatic test_random_bgr();
    write_order(y2rgb_pkg::ORDER_BGR);
    repeat (400) send_macropixel(random_macropixel(1'b0));
  endtask

  task automatic test_random_rgb();
    write_order(y2rgb_pkg::ORDER_RGB);
    repeat (400) send_macropixel(random_macropixel(1'b0));
  endtask

  // Back-to-back stream with the output always ready
  task automatic test_full_rate();
    write_order(y2rgb_pkg::ORDER_BGR);
    steady_run = 1'b1;
    repeat (350) send_macropixel(random_macropixel(1'($urandom_range(0, 1))));
    steady_run = 1'b0;
  endtask

  task automatic test_clamp_rails();
    write_order(y2rgb_pkg::ORDER_RGB);
    repeat (380) send_macropixel(random_macropixel(1'b1));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_order();
    test_directed_extremes();
    test_random_bgr();
    test_random_rgb();
    test_full_rate();
    test_clamp_rails();
    drain_pipeline();
    $display("sent %0d macropixels, checked %0d pixel pairs, %0d order writes",
             n_sent, n_checked, n_order_writes);
    $display("channels on a rail: %0d, frame ends passed: %0d, mismatches: %0d",
             n_rail, n_frame_end, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/y2rgb_pkg.sv
rtl/core/y2rgb_chroma.sv
rtl/core/y2rgb_lane.sv
rtl/core/yuyv422_to_rgb_converter.sv
tb/tb_yuyv422_to_rgb_converter.sv
